[sv/pre_pkg.sv]
// Shared constants, payload types and divider response type for the pulse rate estimator.
`default_nettype none

package pre_pkg;

  localparam int SAMPLE_WINDOW   = 100;
  localparam int INTERVAL_WINDOW = 100;

  localparam int SAMPLE_W  = 12;
  localparam int OFFSET_W  = 12;
  localparam int TIME_W    = 32;
  localparam int BPM_W     = 16;
  localparam int COUNT_W   = 16;

  localparam int OFFSET_RESET   = 200;
  localparam int INTERVAL_RESET = 400;
  localparam int MS_PER_MINUTE  = 60000;
  localparam int BPM_MAX        = (1 << BPM_W) - 1;

  localparam int SPOS_W = $clog2(SAMPLE_WINDOW);
  localparam int IPOS_W = (INTERVAL_WINDOW > 1) ? $clog2(INTERVAL_WINDOW) : 1;
  localparam int SSUM_W = SAMPLE_W + $clog2(SAMPLE_WINDOW + 1);
  localparam int ISUM_W = TIME_W + $clog2(INTERVAL_WINDOW + 1);

  // bpm = DIVIDEND / interval_sum
  localparam int DIVIDEND = MS_PER_MINUTE * INTERVAL_WINDOW;
  localparam int DIV_W    = $clog2(DIVIDEND + 1);
  localparam int DCNT_W   = $clog2(DIV_W + 1);
  localparam int SAT_W    = DIV_W + BPM_W + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic               led_on;
    logic               beat;
    logic [BPM_W-1:0]   bpm;
    logic [COUNT_W-1:0] beat_count;
  } out_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[sv/pre_divider.sv]
// Bit-serial restoring divider: constant dividend over a registered divisor, one quotient bit per cycle.
`default_nettype none

module pre_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pre_pkg::DIV_W-1:0]   divisor,
  output pre_pkg::div_rsp_t                rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [pre_pkg::DCNT_W-1:0]   cnt_r;
  logic [pre_pkg::DIV_W-1:0]    dvd_r;
  logic [pre_pkg::DIV_W-1:0]    rem_r;
  logic [pre_pkg::DIV_W-1:0]    quot_r;
  logic [pre_pkg::DIV_W-1:0]    dsr_r;

  logic [pre_pkg::DIV_W:0]      trial;
  logic [pre_pkg::DIV_W:0]      diff;
  logic                         fits;

  // bring down the next dividend bit and try a subtract
  assign trial = {rem_r, dvd_r[pre_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = ~diff[pre_pkg::DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= pre_pkg::DCNT_W'(pre_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pre_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
      dvd_r  <= pre_pkg::DIV_W'(pre_pkg::DIVIDEND);
    end else if (busy_r) begin
      rem_r  <= fits ? diff[pre_pkg::DIV_W-1:0] : trial[pre_pkg::DIV_W-1:0];
      quot_r <= {quot_r[pre_pkg::DIV_W-2:0], fits};
      dvd_r  <= {dvd_r[pre_pkg::DIV_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

[sv/pulse_rate_estimator_unit.sv]
// Top level of the pulse rate estimator: sample and interval windows, beat detection, bpm.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  in_data  (sample, now_ms)
//   out      out  out_valid/ out_stall out_data (led_on, beat, bpm, beat_count)
//   cfg      in   cfg_we               cfg_wdata (beat_offset)
//
// An item passes the load, update and check states, then the bit-serial divider that
// produces one quotient bit per cycle, then the finish state. When the interval sum
// is zero or larger than the dividend the divider is skipped.
// Synchronous active-low reset; both windows read as zero until first written.
// A result waits in the output register while the next item is taken in; a
// stalled output holds the block only when the next result is ready.
`default_nettype none

module pulse_rate_estimator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire pre_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output pre_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [pre_pkg::OFFSET_W-1:0]   cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_UPDT = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [pre_pkg::OFFSET_W-1:0] offset_r;
  logic [pre_pkg::SAMPLE_W-1:0] sample_r;
  logic [pre_pkg::TIME_W-1:0]   now_r;

  logic [pre_pkg::SAMPLE_W-1:0] smem [pre_pkg::SAMPLE_WINDOW];
  logic [pre_pkg::SAMPLE_W-1:0] smem_rd_r;
  logic [pre_pkg::TIME_W-1:0]   imem [pre_pkg::INTERVAL_WINDOW];
  logic [pre_pkg::TIME_W-1:0]   imem_rd_r;

  logic [pre_pkg::SPOS_W-1:0]   spos_r;
  logic                         swrap_r;
  logic [pre_pkg::IPOS_W-1:0]   ipos_r;
  logic                         iwrap_r;

  logic [pre_pkg::SSUM_W-1:0]   ssum_r;
  logic [pre_pkg::SAMPLE_W-1:0] prev_r;
  logic [pre_pkg::TIME_W-1:0]   last_beat_r;
  logic [pre_pkg::TIME_W-1:0]   cur_int_r;
  logic [pre_pkg::ISUM_W-1:0]   isum_r;
  logic [pre_pkg::COUNT_W-1:0]  beats_r;

  logic                         led_p_r;
  logic                         beat_p_r;
  logic [pre_pkg::BPM_W-1:0]    bpm_p_r;

  logic                         out_valid_r;
  pre_pkg::out_t                out_data_r;

  logic                         in_xfer;
  logic                         out_free;
  logic                         div_start;
  pre_pkg::div_rsp_t            div_rsp;

  logic [pre_pkg::SAMPLE_W-1:0] s_old;
  logic [pre_pkg::TIME_W-1:0]   i_old;
  logic [pre_pkg::SSUM_W-1:0]   ssum_new;
  logic [pre_pkg::SSUM_W-1:0]   scaled;
  logic [pre_pkg::SSUM_W-1:0]   prev_scaled;
  logic [pre_pkg::SSUM_W:0]     level;
  logic                         led;
  logic                         beat;
  logic                         sum_out_of_range;
  logic [pre_pkg::BPM_W-1:0]    bpm_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // entries never written read as zero
  assign s_old = swrap_r ? smem_rd_r : '0;
  assign i_old = iwrap_r ? imem_rd_r : '0;

  assign ssum_new    = ssum_r - pre_pkg::SSUM_W'(s_old) + pre_pkg::SSUM_W'(sample_r);
  assign scaled      = pre_pkg::SSUM_W'(sample_r) * pre_pkg::SSUM_W'(pre_pkg::SAMPLE_WINDOW);
  assign prev_scaled = pre_pkg::SSUM_W'(prev_r) * pre_pkg::SSUM_W'(pre_pkg::SAMPLE_WINDOW);
  assign level       = (pre_pkg::SSUM_W+1)'(offset_r)
                       * (pre_pkg::SSUM_W+1)'(pre_pkg::SAMPLE_WINDOW)
                       + (pre_pkg::SSUM_W+1)'(ssum_new);
  assign led         = scaled > ssum_new;
  assign beat        = ({1'b0, prev_scaled} < level) && ({1'b0, scaled} > level);

  assign sum_out_of_range = (isum_r == '0)
                            || (isum_r > pre_pkg::ISUM_W'(pre_pkg::DIVIDEND));
  assign div_start = (state_r == ST_CHK) && !sum_out_of_range;

  assign bpm_sat = (pre_pkg::SAT_W'(div_rsp.quot) > pre_pkg::SAT_W'(pre_pkg::BPM_MAX))
                   ? pre_pkg::BPM_W'(pre_pkg::BPM_MAX) : pre_pkg::BPM_W'(div_rsp.quot);

  pre_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (isum_r[pre_pkg::DIV_W-1:0]),
    .rsp     (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_UPDT;
      ST_UPDT: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = sum_out_of_range ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= pre_pkg::OFFSET_W'(pre_pkg::OFFSET_RESET);
      spos_r      <= '0;
      swrap_r     <= 1'b0;
      ipos_r      <= '0;
      iwrap_r     <= 1'b0;
      ssum_r      <= '0;
      prev_r      <= '0;
      last_beat_r <= '0;
      cur_int_r   <= pre_pkg::TIME_W'(pre_pkg::INTERVAL_RESET);
      isum_r      <= '0;
      beats_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) offset_r <= cfg_wdata;
      if (out_valid_r && !out_stall && state_r != ST_FIN) out_valid_r <= 1'b0;

      case (state_r)
        ST_LOAD: begin
          ssum_r <= ssum_new;
          prev_r <= sample_r;
          if (spos_r == pre_pkg::SPOS_W'(pre_pkg::SAMPLE_WINDOW - 1)) begin
            spos_r  <= '0;
            swrap_r <= 1'b1;
          end else begin
            spos_r <= spos_r + 1'b1;
          end
          if (beat) begin
            cur_int_r   <= now_r - last_beat_r;
            last_beat_r <= now_r;
            beats_r     <= beats_r + 1'b1;
          end
          // drop the oldest interval now, add the current one next cycle
          isum_r <= isum_r - pre_pkg::ISUM_W'(i_old);
        end
        ST_UPDT: begin
          isum_r <= isum_r + pre_pkg::ISUM_W'(cur_int_r);
          if (ipos_r == pre_pkg::IPOS_W'(pre_pkg::INTERVAL_WINDOW - 1)) begin
            ipos_r  <= '0;
            iwrap_r <= 1'b1;
          end else begin
            ipos_r <= ipos_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_data.sample;
      now_r    <= in_data.now_ms;
    end
    if (state_r == ST_LOAD) begin
      led_p_r  <= led;
      beat_p_r <= beat;
    end
    if (state_r == ST_CHK && sum_out_of_range) bpm_p_r <= '0;
    if (state_r == ST_DIV && div_rsp.done) bpm_p_r <= bpm_sat;
    if (state_r == ST_FIN && out_free) begin
      out_data_r.led_on     <= led_p_r;
      out_data_r.beat       <= beat_p_r;
      out_data_r.bpm        <= bpm_p_r;
      out_data_r.beat_count <= beats_r;
    end
  end

  // sample window memory
  always_ff @(posedge clk) begin
    if (in_xfer) smem_rd_r <= smem[spos_r];
    if (state_r == ST_LOAD) smem[spos_r] <= sample_r;
  end

  // interval window memory
  always_ff @(posedge clk) begin
    if (in_xfer) imem_rd_r <= imem[ipos_r];
    if (state_r == ST_UPDT) imem[ipos_r] <= cur_int_r;
  end

`ifndef SYNTHESIS
  // a beat crosses a level at or above the mean, so the LED is lit too
  a_beat_lights_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.beat || out_data_r.led_on))
    else $error("beat reported without led_on");

  a_xfer_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_LOAD))
    else $error("accepted item did not start processing");

  a_spos_range: assert property (@(posedge clk) disable iff (!rst_n)
    spos_r <= pre_pkg::SPOS_W'(pre_pkg::SAMPLE_WINDOW - 1))
    else $error("sample window position out of range");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_beat_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && beat |=> (beats_r == $past(beats_r) + 1'b1))
    else $error("beat counter did not advance on a beat");
`endif

endmodule

`default_nettype wire
